// ----- rtl/slcfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

    localparam logic [7:0]  SOF_FIRST      = 8'h55;
    localparam logic [7:0]  SOF_SECOND     = 8'hAA;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  LENGTH_CAP     = 8'd252;
    localparam logic [7:0]  MAX_LEN_RESET  = 8'd122;

    typedef enum logic [1:0] {
        KIND_TYPE     = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_ACCEPTED = 2'd2,
        KIND_CRC_BAD  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] body_length;
        logic       last;
    } out_item_t;

    // one byte of crc16-ccitt, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/slcfr_out_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slcfr_out_skid
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push_valid,
    input  wire slcfr_pkg::out_item_t push_item,
    output logic                   push_ready,
    output logic                   m_valid,
    input  wire                    m_ready,
    output slcfr_pkg::out_item_t   m_item
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    slcfr_pkg::out_item_t out_reg;
    slcfr_pkg::out_item_t out_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    slcfr_pkg::out_item_t skid_reg;
    slcfr_pkg::out_item_t skid_next;

    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_item     = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push_valid;
                if (push_valid)
                    out_next = push_item;
            end
        end
        else if (push_valid)
        begin
            // output stalled: park the new request
            skid_valid_next = 1'b1;
            skid_next       = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !(push_valid && push_ready))
        else $error("request taken while skid is full");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_ready) |=> (out_valid_reg && out_reg == $past(skid_reg)
                                         && !skid_valid_reg))
        else $error("skid entry not moved to output register");

endmodule

`default_nettype wire

// ----- rtl/sof_length_crc16_frame_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Serial frame receiver: takes one received byte per request on the s_ side,
// hunts for the 0x55 0xAA start marker, reads a big-endian 16-bit body length,
// streams the type and payload bytes out on the m_ side and closes each frame
// with a verdict (accepted or crc mismatch, tlast high) after checking the
// big-endian crc16-ccitt over length and body. A body length of zero or above
// the configured maximum (capped at 252) drops the frame silently and swallows
// the next two bytes. One byte is taken every clock cycle while s_tready is high; its result,
// if any, goes into the output register, or into the skid entry while the output stalls. A two-entry output stage
// lets input continue while one result waits, so s_tready drops only when two
// results are pending. cfg_data writes the maximum body length (reset 122).
module sof_length_crc16_frame_receiver_top
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,    // [7:0] data, [15:8] body_length
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data
);

    typedef enum logic [8:0] {
        PH_HUNT0   = 9'b000000001,
        PH_HUNT1   = 9'b000000010,
        PH_LEN_HI  = 9'b000000100,
        PH_LEN_LO  = 9'b000001000,
        PH_TYPE    = 9'b000010000,
        PH_PAYLOAD = 9'b000100000,
        PH_CRC_HI  = 9'b001000000,
        PH_CRC_LO  = 9'b010000000,
        PH_SKIP    = 9'b100000000
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  max_len_reg;
    logic [7:0]  len_hi_reg;
    logic [7:0]  len_hi_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  crc_hi_reg;
    logic [7:0]  crc_hi_next;
    logic        skip_reg;
    logic        skip_next;

    logic                 accept;
    logic                 push_valid;
    slcfr_pkg::out_item_t push_item;
    slcfr_pkg::out_item_t m_item;
    logic [7:0]           limit;
    logic [15:0]          crc_upd;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign limit     = (max_len_reg > slcfr_pkg::LENGTH_CAP) ? slcfr_pkg::LENGTH_CAP
                                                              : max_len_reg;
    assign crc_upd   = slcfr_pkg::crc_byte(crc_reg, s_tdata);

    always_comb
    begin
        phase_next  = phase_reg;
        len_hi_next = len_hi_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        skip_next   = skip_reg;
        push_valid  = 1'b0;
        push_item.kind        = slcfr_pkg::KIND_TYPE;
        push_item.data        = s_tdata;
        push_item.body_length = 8'd0;
        push_item.last        = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (s_tdata == slcfr_pkg::SOF_SECOND)
                    begin
                        crc_next   = slcfr_pkg::CRC_INIT;
                        phase_next = PH_LEN_HI;
                    end
                    else if (s_tdata != slcfr_pkg::SOF_FIRST)
                        phase_next = PH_HUNT0;
                end
                PH_LEN_HI:
                begin
                    len_hi_next = s_tdata;
                    crc_next    = crc_upd;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = s_tdata;
                    crc_next = crc_upd;
                    // length above 255 fails on the high byte alone
                    if (len_hi_reg != 8'd0 || s_tdata == 8'd0 || s_tdata > limit)
                    begin
                        skip_next  = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                        phase_next = PH_TYPE;
                end
                PH_SKIP:
                begin
                    skip_next = 1'b0;
                    if (!skip_reg)
                        phase_next = PH_HUNT0;
                end
                PH_TYPE:
                begin
                    crc_next   = crc_upd;
                    count_next = 8'd1;
                    phase_next = (len_reg <= 8'd1) ? PH_CRC_HI : PH_PAYLOAD;
                    push_valid = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    crc_next   = crc_upd;
                    count_next = count_reg + 8'd1;
                    if (count_next >= len_reg)
                        phase_next = PH_CRC_HI;
                    push_valid     = 1'b1;
                    push_item.kind = slcfr_pkg::KIND_PAYLOAD;
                end
                PH_CRC_HI:
                begin
                    crc_hi_next = s_tdata;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    phase_next = PH_HUNT0;
                    push_valid = 1'b1;
                    push_item.kind = ({crc_hi_reg, s_tdata} == crc_reg)
                                     ? slcfr_pkg::KIND_ACCEPTED : slcfr_pkg::KIND_CRC_BAD;
                    push_item.data        = 8'd0;
                    push_item.body_length = len_reg;
                    push_item.last        = 1'b1;
                end
                default:
                begin
                    phase_next = (s_tdata == slcfr_pkg::SOF_FIRST) ? PH_HUNT1 : PH_HUNT0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT0;
            max_len_reg <= slcfr_pkg::MAX_LEN_RESET;
            len_hi_reg  <= 8'd0;
            len_reg     <= 8'd0;
            count_reg   <= 8'd0;
            crc_reg     <= slcfr_pkg::CRC_INIT;
            crc_hi_reg  <= 8'd0;
            skip_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            skip_reg   <= skip_next;
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
        end
    end

    slcfr_out_skid u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_item     (m_item)
    );

    assign m_tdata = {m_item.body_length, m_item.data};
    assign m_tuser = m_item.kind;
    assign m_tlast = m_item.last;

endmodule

`default_nettype wire

// ----- test/sof_length_crc16_frame_receiver_top_tb.sv -----
`timescale 1ns / 1ps

module sof_length_crc16_frame_receiver_top_tb;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    typedef enum logic [3:0] {
        RX_HUNT0   = 4'd0,
        RX_HUNT1   = 4'd1,
        RX_LEN_HI  = 4'd2,
        RX_LEN_LO  = 4'd3,
        RX_TYPE    = 4'd4,
        RX_PAYLOAD = 4'd5,
        RX_CRC_HI  = 4'd6,
        RX_CRC_LO  = 4'd7,
        RX_SKIP    = 4'd8
    } rx_phase_t;

    // bitwise crc16-ccitt step, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ slcfr_pkg::CRC_POLY;
        end
        return r;
    endfunction

    class frame_scoreboard;
        rx_phase_t            phase;
        logic [15:0]          len_seen;
        logic [7:0]           body_count;
        logic [15:0]          crc;
        logic [7:0]           crc_hi;
        logic [1:0]           skip_left;
        logic [7:0]           max_len;
        slcfr_pkg::out_item_t expected_q[$];
        int                   fails;

        function new();
            phase      = RX_HUNT0;
            len_seen   = '0;
            body_count = '0;
            crc        = slcfr_pkg::CRC_INIT;
            crc_hi     = '0;
            skip_left  = '0;
            max_len    = slcfr_pkg::MAX_LEN_RESET;
            fails      = 0;
        endfunction

        function void note_byte(input logic [7:0] b);
            slcfr_pkg::out_item_t r;
            logic [7:0]           lim;
            lim = (max_len > slcfr_pkg::LENGTH_CAP) ? slcfr_pkg::LENGTH_CAP : max_len;
            r   = '0;
            case (phase)
                RX_HUNT1:
                begin
                    if (b == slcfr_pkg::SOF_SECOND)
                    begin
                        crc   = slcfr_pkg::CRC_INIT;
                        phase = RX_LEN_HI;
                    end
                    else if (b != slcfr_pkg::SOF_FIRST)
                        phase = RX_HUNT0;
                end
                RX_LEN_HI:
                begin
                    len_seen = {b, 8'h00};
                    crc      = crc16_update(crc, b);
                    phase    = RX_LEN_LO;
                end
                RX_LEN_LO:
                begin
                    len_seen[7:0] = b;
                    crc           = crc16_update(crc, b);
                    if (len_seen == 16'd0 || len_seen > {8'h00, lim})
                    begin
                        skip_left = 2'd2;
                        phase     = RX_SKIP;
                    end
                    else
                        phase = RX_TYPE;
                end
                RX_SKIP:
                begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0)
                        phase = RX_HUNT0;
                end
                RX_TYPE:
                begin
                    crc        = crc16_update(crc, b);
                    body_count = 8'd1;
                    phase      = ({8'h00, body_count} >= len_seen) ? RX_CRC_HI : RX_PAYLOAD;
                    r.kind     = slcfr_pkg::KIND_TYPE;
                    r.data     = b;
                    expected_q.push_back(r);
                end
                RX_PAYLOAD:
                begin
                    crc        = crc16_update(crc, b);
                    body_count = body_count + 8'd1;
                    if ({8'h00, body_count} >= len_seen)
                        phase = RX_CRC_HI;
                    r.kind = slcfr_pkg::KIND_PAYLOAD;
                    r.data = b;
                    expected_q.push_back(r);
                end
                RX_CRC_HI:
                begin
                    crc_hi = b;
                    phase  = RX_CRC_LO;
                end
                RX_CRC_LO:
                begin
                    r.kind        = ({crc_hi, b} == crc) ? slcfr_pkg::KIND_ACCEPTED
                                                         : slcfr_pkg::KIND_CRC_BAD;
                    r.body_length = len_seen[7:0];
                    r.last        = 1'b1;
                    phase         = RX_HUNT0;
                    expected_q.push_back(r);
                end
                default:
                    phase = (b == slcfr_pkg::SOF_FIRST) ? RX_HUNT1 : RX_HUNT0;
            endcase
        endfunction

        function void check_result(input logic [1:0] kind, input logic [7:0] data,
                                   input logic [7:0] body_length, input logic last);
            slcfr_pkg::out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d data %0h body_length %0d last %0b",
                       kind, data, body_length, last);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                fails++;
            end
            if (data !== e.data)
            begin
                $error("data: expected %0h, actual %0h", e.data, data);
                fails++;
            end
            if (body_length !== e.body_length)
            begin
                $error("body_length: expected %0d, actual %0d", e.body_length, body_length);
                fails++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, last);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;              // [7:0] data, [15:8] body_length
    logic [1:0]  m_tuser;              // [1:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    frame_scoreboard sb = new();
    int              bytes_sent = 0;
    bit              tx_steady = 1'b0;
    bit              rx_steady = 1'b0;
    int              stall_left = 0;

    sof_length_crc16_frame_receiver_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver backpressure: mostly short stalls, a few long, with stall-free stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready = 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
        if ($urandom_range(0, 299) == 0)
            rx_steady = !rx_steady;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return slcfr_pkg::SOF_FIRST;
            1: return slcfr_pkg::SOF_SECOND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drive_frame(input logic [15:0] len, input int fill,
                               input bit bad_crc, input bit truncate);
        logic [15:0] crc;
        logic [7:0]  b;
        int          n;
        crc = slcfr_pkg::CRC_INIT;
        n   = truncate ? $urandom_range(0, int'(len) - 1) : int'(len);
        push_byte(slcfr_pkg::SOF_FIRST);
        push_byte(slcfr_pkg::SOF_SECOND);
        crc = crc16_update(crc, len[15:8]);
        push_byte(len[15:8]);
        crc = crc16_update(crc, len[7:0]);
        push_byte(len[7:0]);
        for (int i = 0; i < n; i++)
        begin
            if (fill == FILL_ZERO)
                b = 8'h00;
            else if (fill == FILL_ONES)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            crc = crc16_update(crc, b);
            push_byte(b);
        end
        if (!truncate)
        begin
            if (bad_crc)
                crc = crc ^ 16'($urandom_range(1, 65535));
            push_byte(crc[15:8]);
            push_byte(crc[7:0]);
        end
    endtask

    // marker and an illegal length, then the two bytes that get swallowed
    task automatic send_bad_length(input logic [15:0] len);
        push_byte(slcfr_pkg::SOF_FIRST);
        push_byte(slcfr_pkg::SOF_SECOND);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(noise_byte());
        push_byte(noise_byte());
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        // a dropped frame gives no result, so let the pipeline settle
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_length(input logic [7:0] v);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.max_len = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_step();
        int          r;
        int          lim;
        int          n;
        logic [15:0] bad;
        r   = $urandom_range(0, 99);
        lim = (sb.max_len > slcfr_pkg::LENGTH_CAP) ? int'(slcfr_pkg::LENGTH_CAP)
                                                   : int'(sb.max_len);
        if ($urandom_range(0, 6) == 0)
            tx_steady = !tx_steady;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, lim)
                                        : $urandom_range(1, (lim < 8) ? lim : 8);
        if (r < 68)
            drive_frame(16'(n), FILL_RANDOM, $urandom_range(0, 6) == 0, 1'b0);
        else if (r < 78)
        begin
            case ($urandom_range(0, 2))
                0: bad = 16'd0;
                1: bad = 16'($urandom_range(lim + 1, 255));
                default: bad = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
            endcase
            send_bad_length(bad);
        end
        else if (r < 85)
            drive_frame(16'(n), FILL_RANDOM, 1'b0, 1'b1);
        else if (r < 94)
            repeat ($urandom_range(1, 6)) push_byte(noise_byte());
        else
        begin
            // repeated first marker byte keeps the hunt armed
            repeat ($urandom_range(1, 3)) push_byte(slcfr_pkg::SOF_FIRST);
            drive_frame(16'(n), FILL_RANDOM, 1'b0, 1'b0);
        end
    endtask

    initial
    begin
        logic [7:0] settings[5];
        int         target;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, at the reset maximum
        drive_frame(16'd1, FILL_ZERO, 1'b0, 1'b0);
        drive_frame(16'd2, FILL_ONES, 1'b1, 1'b0);
        push_byte(slcfr_pkg::SOF_FIRST);
        drive_frame(16'd3, FILL_RANDOM, 1'b0, 1'b0);
        send_bad_length(16'd0);
        send_bad_length(16'(slcfr_pkg::MAX_LEN_RESET) + 16'd1);
        send_bad_length(16'h0100);

        write_max_length(8'd1);
        drive_frame(16'd1, FILL_RANDOM, 1'b0, 1'b0);
        send_bad_length(16'd2);

        write_max_length(slcfr_pkg::LENGTH_CAP);
        drive_frame(16'(slcfr_pkg::LENGTH_CAP), FILL_RANDOM, 1'b0, 1'b0);
        send_bad_length(16'(slcfr_pkg::LENGTH_CAP) + 16'd1);

        settings = '{8'd7, slcfr_pkg::LENGTH_CAP, 8'($urandom_range(1, 252)), 8'd1,
                     slcfr_pkg::MAX_LEN_RESET};
        foreach (settings[p])
        begin
            write_max_length(settings[p]);
            target = bytes_sent + 180;
            while (bytes_sent < target)
                random_step();
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $error("results never arrived: %0d", sb.expected_q.size());
            sb.fails++;
        end
        if (sb.fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
